// File: rtl/core/shng_pkg.sv
package shng_pkg;

  localparam int NumBucketsDefault  = 1024;
  localparam int BucketDepthDefault = 4;

  localparam logic [31:0] PrimeX = 32'd73856093;
  localparam logic [31:0] PrimeY = 32'd19349663;
  localparam logic [31:0] PrimeZ = 32'd83492791;

  localparam logic [30:0] CellSizeReset = 31'd65536;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdFind   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  localparam int IdxW = 24;

  typedef struct packed {
    logic [1:0]      cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [IdxW-1:0] particle_index;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [9:0]      bucket_id;
    logic [4:0]      neighbor;
    logic [2:0]      count;
    logic [IdxW-1:0] entry_a;
    logic [IdxW-1:0] entry_b;
    logic [IdxW-1:0] entry_c;
    logic [IdxW-1:0] entry_d;
    logic            last;
  } rsp_t;

endpackage

// File: rtl/core/shng_if.sv
interface shng_req_if;
  import shng_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface shng_rsp_if;
  import shng_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface shng_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/shng_ram.sv
module shng_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/spatial_hash_neighbor_grid_unit.sv
// Spatial hash grid for particle neighbor search. Each request is a transfer on
// req: insert (cmd 0) adds particle_index to the bucket of the cell that holds
// the position, find (cmd 1) returns 27 results, one per neighbor cell (y outer,
// z middle, x inner, -1..+1), clear (cmd 2) empties every bucket; cmd 3 is
// dropped. Cell coordinates come from a restoring divider that handles one
// quotient bit per cycle for all three axes together, the hash products use
// one 32x32 multiplier shared over the axes, the bucket number is taken from
// the hash by a reciprocal multiply, and the bucket memories have one read and
// one write port. A clear empties one bucket fill word per cycle. An insert
// into a full bucket stores nothing and returns status 1. A result holds
// the block until its transfer on rsp. After reset the block runs the same
// clearing pass before it accepts a request; cell_size writes are taken at
// any time and apply from the next accepted request. The fill word of a
// bucket holds the count; reset sets the state, cell_size, clr_addr, cmd and
// rsp.valid, and the clearing pass then zeroes every fill word.
module spatial_hash_neighbor_grid_unit #(
  parameter int NUM_BUCKETS  = shng_pkg::NumBucketsDefault,
  parameter int BUCKET_DEPTH = shng_pkg::BucketDepthDefault
) (
  input logic clk,
  input logic rst,
  shng_cfg_if.sink    cfg,
  shng_req_if.sink    req,
  shng_rsp_if.source  rsp
);
  import shng_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int SW = BW + DW;
  localparam int FDEPTH = (NUM_BUCKETS > 1) ? NUM_BUCKETS : 2;
  localparam int SDEPTHR = 1 << SW;

  // reciprocal of the bucket count, exact for every 32-bit hash
  localparam int LB = $clog2(NUM_BUCKETS);
  localparam logic [32:0] RecipM = 33'(((64'd1 << (32 + LB)) + 64'(NUM_BUCKETS) - 64'd1)
                                       / 64'(NUM_BUCKETS));

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_NB    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_HASH  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FWT   = 4'd7;
  localparam logic [3:0] S_ERD   = 4'd8;
  localparam logic [3:0] S_EWT   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_RED   = 4'd11;

  logic [3:0]  state;
  logic [30:0] cell_size;
  logic [1:0]  cmd;
  logic [IdxW-1:0] pidx;

  // divider state: magnitude, remainder per axis
  logic [31:0] quo [3];
  logic [31:0] rem [3];
  logic        neg [3];
  logic [5:0]  dcnt;
  logic [30:0] divisor;
  logic signed [33:0] cell_coord [3];

  // neighbor walk and hashing
  logic [4:0]  k;
  logic [1:0]  dx, dy, dz;
  logic [1:0]  maxis;
  logic [31:0] prod [3];
  logic [31:0] hash;
  logic [31:0] qrec;
  logic [BW-1:0] bucket;
  logic [2:0]  fill;
  logic [DW:0] eidx;
  logic [IdxW-1:0] ent [4];
  logic        status;
  logic [BW-1:0] clr_addr;

  // memories
  logic          f_we;
  logic [BW-1:0] f_waddr, f_raddr;
  logic [2:0]    f_wdata, f_rdata;
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [IdxW-1:0] s_rdata;

  shng_ram #(.Width(3), .Depth(FDEPTH)) u_fill (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  shng_ram #(.Width(IdxW), .Depth(SDEPTHR)) u_store (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(pidx),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  // one divider step for an axis
  function automatic logic [63:0] div_step(input logic [31:0] r, input logic [31:0] q,
                                           input logic [30:0] d);
    logic [32:0] t;
    logic [31:0] r2, q2;
    begin
      t  = {r, q[31]};
      q2 = {q[30:0], 1'b0};
      if (t >= {2'b0, d}) begin
        r2 = 32'(t - {2'b0, d});
        q2[0] = 1'b1;
      end else begin
        r2 = t[31:0];
      end
      div_step = {r2, q2};
    end
  endfunction

  // multiplier operand for the current axis
  logic signed [33:0] mcell;
  logic [31:0] mprime;
  logic [1:0]  moff;
  always_comb begin
    case (maxis)
      2'd0: begin mcell = cell_coord[0]; mprime = PrimeX; moff = dx; end
      2'd1: begin mcell = cell_coord[1]; mprime = PrimeY; moff = dy; end
      default: begin mcell = cell_coord[2]; mprime = PrimeZ; moff = dz; end
    endcase
  end
  logic [31:0] mcoord;
  logic [31:0] mres;
  assign mcoord = 32'(mcell + 34'(signed'({1'b0, moff})) - 34'sd1);
  assign mres   = mcoord * mprime;

  // bucket number: quotient by reciprocal, then the remainder
  logic [64:0]   rprod;
  logic [31:0]   hrem;
  logic [BW-1:0] hbucket;
  assign rprod   = 65'(hash) * 65'(RecipM);
  assign hrem    = hash - qrec * 32'(NUM_BUCKETS);
  assign hbucket = BW'(hrem);

  // memory ports
  always_comb begin
    f_we    = 1'b0;
    f_waddr = bucket;
    f_wdata = 3'(f_rdata + 3'd1);
    f_raddr = (state == S_FRD) ? hbucket : bucket;
    s_we    = 1'b0;
    s_waddr = {bucket, f_rdata[DW-1:0]};
    s_raddr = {bucket, eidx[DW-1:0]};
    if (state == S_CLR) begin
      f_we    = 1'b1;
      f_waddr = clr_addr;
      f_wdata = 3'd0;
    end else if (state == S_FWT && cmd == CmdInsert && f_rdata < 3'(BUCKET_DEPTH)) begin
      f_we = 1'b1;
      s_we = 1'b1;
    end
  end

  logic out_fire;
  assign out_fire = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cell_size <= CellSizeReset;
      clr_addr  <= '0;
      cmd       <= CmdInsert;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        cell_size <= cfg.data;
      end
      if (out_fire) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (clr_addr == BW'(NUM_BUCKETS - 1)) begin
            clr_addr <= '0;
            if (cmd == CmdClear) begin
              rsp.valid <= 1'b1;
              rsp.data  <= '{status: 1'b0, bucket_id: 10'd0, neighbor: 5'd0, count: 3'd0,
                             entry_a: '0, entry_b: '0, entry_c: '0, entry_d: '0,
                             last: 1'b1};
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            clr_addr <= BW'(clr_addr + 1'b1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd  <= req.data.cmd;
            pidx <= req.data.particle_index;
            if (req.data.cmd == CmdClear) begin
              state <= S_CLR;
            end else if (req.data.cmd != 2'd3) begin
              divisor <= (cell_size == '0) ? 31'd1 : cell_size;
              neg[0] <= req.data.pos_x[31];
              neg[1] <= req.data.pos_y[31];
              neg[2] <= req.data.pos_z[31];
              quo[0] <= req.data.pos_x[31] ? 32'(-req.data.pos_x) : req.data.pos_x;
              quo[1] <= req.data.pos_y[31] ? 32'(-req.data.pos_y) : req.data.pos_y;
              quo[2] <= req.data.pos_z[31] ? 32'(-req.data.pos_z) : req.data.pos_z;
              rem[0] <= '0;
              rem[1] <= '0;
              rem[2] <= '0;
              dcnt   <= '0;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // one quotient bit per cycle per axis, then floor for negatives
          if (dcnt == 6'd32) begin
            for (int a = 0; a < 3; a++) begin
              if (neg[a]) begin
                cell_coord[a] <= -34'(signed'({2'b0, quo[a]}))
                                 - ((rem[a] != '0) ? 34'sd1 : 34'sd0);
              end else begin
                cell_coord[a] <= 34'(signed'({2'b0, quo[a]}));
              end
            end
            k  <= '0;
            dx <= (cmd == CmdInsert) ? 2'd1 : 2'd0;
            dy <= (cmd == CmdInsert) ? 2'd1 : 2'd0;
            dz <= (cmd == CmdInsert) ? 2'd1 : 2'd0;
            state <= S_NB;
          end else begin
            for (int a = 0; a < 3; a++) begin
              {rem[a], quo[a]} <= div_step(rem[a], quo[a], divisor);
            end
            dcnt <= 6'(dcnt + 1'b1);
          end
        end
        S_NB: begin
          maxis <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          // one product per cycle through the shared multiplier
          prod[maxis] <= mres;
          if (maxis == 2'd2) begin
            state <= S_HASH;
          end else begin
            maxis <= 2'(maxis + 1'b1);
          end
        end
        S_HASH: begin
          hash  <= prod[0] ^ prod[1] ^ prod[2];
          state <= S_RED;
        end
        S_RED: begin
          qrec  <= 32'(rprod >> (32 + LB));
          state <= S_FRD;
        end
        S_FRD: begin
          // fill read of the new bucket is issued on this edge
          bucket <= hbucket;
          state  <= S_FWT;
        end
        S_FWT: begin
          // fill read is valid now; insert writes on this edge when the bucket has room
          if (cmd == CmdInsert) begin
            if (f_rdata < 3'(BUCKET_DEPTH)) begin
              fill   <= 3'(f_rdata + 3'd1);
              status <= 1'b0;
            end else begin
              fill   <= f_rdata;
              status <= 1'b1;
            end
          end else begin
            fill   <= f_rdata;
            status <= 1'b0;
          end
          eidx  <= '0;
          ent[0] <= '0;
          ent[1] <= '0;
          ent[2] <= '0;
          ent[3] <= '0;
          state <= S_ERD;
        end
        S_ERD: begin
          if (3'(eidx) >= fill || eidx >= (DW+1)'(BUCKET_DEPTH)) begin
            rsp.valid <= 1'b1;
            rsp.data  <= '{status: status, bucket_id: 10'(bucket), neighbor: k, count: fill,
                           entry_a: ent[0], entry_b: ent[1], entry_c: ent[2],
                           entry_d: ent[3],
                           last: (cmd == CmdInsert) || (k == 5'd26)};
            state <= S_OUT;
          end else begin
            state <= S_EWT;
          end
        end
        S_EWT: begin
          ent[eidx[1:0]] <= s_rdata;
          eidx  <= (DW+1)'(eidx + 1'b1);
          state <= S_ERD;
        end
        S_OUT: begin
          // hold the result until its transfer, then walk on or, after the last, go idle
          if (out_fire) begin
            if (rsp.data.last) begin
              state <= S_IDLE;
            end else begin
              k <= 5'(k + 1'b1);
              if (dx == 2'd2) begin
                dx <= 2'd0;
                if (dz == 2'd2) begin
                  dz <= 2'd0;
                  dy <= 2'(dy + 1'b1);
                end else begin
                  dz <= 2'(dz + 1'b1);
                end
              end else begin
                dx <= 2'(dx + 1'b1);
              end
              state <= S_NB;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("accept while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.data.count <= 3'(BUCKET_DEPTH))) else $error("count too big");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status) |-> (rsp.data.count == 3'(BUCKET_DEPTH)))
    else $error("drop with room");
  a_nb_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.data.neighbor <= 5'd26)) else $error("neighbor range");
`endif

endmodule
